FILE: rtl/core/sfadd_pkg.sv
`timescale 1ns / 1ps
package sfadd_pkg;
   localparam int WordWidth = 32;
   localparam int ExpWidth  = 8;
   localparam int FracWidth = 23;
   localparam int MantWidth = 24;
   localparam int GapLimit  = 24;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [ExpWidth-1:0]  exp_type;
   typedef logic [MantWidth-1:0] mant_type;

   // leading zero count of a 24-bit mantissa (value 24 for zero)
   function automatic logic [4:0] lzc24(input mant_type m);
      logic [4:0] n;
      n = 5'd24;
      for (int i = 0; i < MantWidth; i++) begin
         if (m[i]) n = 5'(MantWidth - 1 - i);
      end
      return n;
   endfunction
endpackage

FILE: rtl/core/sfadd_if.sv
`timescale 1ns / 1ps
interface sfadd_req_if;
   logic valid;
   logic ready;
   logic [31:0] operand_a;
   logic [31:0] operand_b;
   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface sfadd_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] sum_bits;
   modport source (output valid, output sum_bits, input ready);
   modport sink (input valid, input sum_bits, output ready);
endinterface

FILE: rtl/core/single_float_adder_truncating.sv
`timescale 1ns / 1ps
// Truncating single-precision adder, four register stages.
// Each accepted request word passes through stages 1, 2, 3 and 4 in order to its response word.
// Throughput: one word per cycle; a stall holds every stage in place.
// Reset (synchronous, active high) clears the stage valid bits only.
module single_float_adder_truncating (
   input logic clock,
   input logic reset,
   sfadd_req_if.sink   req,
   sfadd_rsp_if.source rsp
);
   import sfadd_pkg::*;

   // whole pipe advances together when the last stage is free
   logic advance;
   logic [3:0] valid_ff, valid_in;
   assign advance = !valid_ff[3] || rsp.ready;
   assign req.ready = advance;
   assign valid_in = {valid_ff[2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= valid_in;
   end

   // stage 1: unpack, order, shift amount
   logic       s1_bypass_ff, s1_bypass_in;
   word_type   s1_pass_ff, s1_pass_in;
   logic       s1_sa_ff, s1_sb_ff;
   exp_type    s1_er_ff, s1_er_in;
   mant_type   s1_big_ff, s1_big_in, s1_small_ff, s1_small_in;
   logic       s1_b_small_ff, s1_b_small_in;
   logic [4:0] s1_gap_ff, s1_gap_in;
   logic       s1_zero_ff, s1_zero_in;

   always_comb begin
      logic [7:0] ea, eb, gap;
      logic a_zero, b_zero;
      ea = req.operand_a[30:23];
      eb = req.operand_b[30:23];
      a_zero = (ea == '0) && (req.operand_a[22:0] == '0);
      b_zero = (eb == '0) && (req.operand_b[22:0] == '0);
      s1_bypass_in = a_zero || b_zero;
      s1_pass_in = a_zero ? req.operand_b : req.operand_a;
      s1_b_small_in = !(ea < eb);
      if (ea < eb) begin
         gap = eb - ea;
         s1_er_in = eb;
         s1_big_in = {1'b1, req.operand_b[22:0]};
         s1_small_in = {1'b1, req.operand_a[22:0]};
      end else begin
         gap = ea - eb;
         s1_er_in = ea;
         s1_big_in = {1'b1, req.operand_a[22:0]};
         s1_small_in = {1'b1, req.operand_b[22:0]};
      end
      s1_zero_in = gap >= 8'(GapLimit);
      s1_gap_in = gap[4:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_bypass_ff <= s1_bypass_in;
         s1_pass_ff <= s1_pass_in;
         s1_sa_ff <= req.operand_a[31];
         s1_sb_ff <= req.operand_b[31];
         s1_er_ff <= s1_er_in;
         s1_big_ff <= s1_big_in;
         s1_small_ff <= s1_small_in;
         s1_b_small_ff <= s1_b_small_in;
         s1_gap_ff <= s1_gap_in;
         s1_zero_ff <= s1_zero_in;
      end
   end

   // stage 2: align and add or subtract
   logic       s2_bypass_ff;
   word_type   s2_pass_ff;
   logic       s2_sr_ff, s2_sr_in;
   logic       s2_same_ff, s2_cancel_ff, s2_cancel_in;
   exp_type    s2_er_ff;
   logic [24:0] s2_m_ff, s2_m_in;

   always_comb begin
      mant_type sm, ma, mb;
      sm = s1_zero_ff ? '0 : (s1_small_ff >> s1_gap_ff);
      ma = s1_b_small_ff ? s1_big_ff : sm;
      mb = s1_b_small_ff ? sm : s1_big_ff;
      s2_cancel_in = 1'b0;
      if (s1_sa_ff == s1_sb_ff) begin
         s2_sr_in = s1_sa_ff;
         s2_m_in = {1'b0, ma} + {1'b0, mb};
      end else if (mb > ma) begin
         s2_sr_in = s1_sb_ff;
         s2_m_in = {1'b0, mb - ma};
      end else begin
         s2_sr_in = s1_sa_ff;
         s2_m_in = {1'b0, ma - mb};
         s2_cancel_in = (ma == mb);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_bypass_ff <= s1_bypass_ff;
         s2_pass_ff <= s1_pass_ff;
         s2_sr_ff <= s2_sr_in;
         s2_same_ff <= s1_sa_ff == s1_sb_ff;
         s2_cancel_ff <= s2_cancel_in;
         s2_er_ff <= s1_er_ff;
         s2_m_ff <= s2_m_in;
      end
   end

   // stage 3: leading zero count and carry handling
   logic       s3_bypass_ff, s3_sr_ff, s3_cancel_ff, s3_carry_ff;
   word_type   s3_pass_ff;
   exp_type    s3_er_ff;
   mant_type   s3_m_ff;
   logic [4:0] s3_lz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_bypass_ff <= s2_bypass_ff;
         s3_pass_ff <= s2_pass_ff;
         s3_sr_ff <= s2_sr_ff;
         s3_cancel_ff <= s2_cancel_ff;
         s3_carry_ff <= s2_same_ff && s2_m_ff[24];
         s3_er_ff <= s2_er_ff;
         s3_m_ff <= s2_m_ff[24] ? s2_m_ff[24:1] : s2_m_ff[23:0];
         s3_lz_ff <= s2_same_ff ? 5'd0 : lzc24(s2_m_ff[23:0]);
      end
   end

   // stage 4: normalize and pack
   word_type s4_sum_ff, s4_sum_in;

   always_comb begin
      mant_type m;
      exp_type  e;
      m = s3_m_ff << s3_lz_ff;
      e = s3_er_ff + exp_type'(s3_carry_ff) - exp_type'(s3_lz_ff);
      priority if (s3_bypass_ff) s4_sum_in = s3_pass_ff;
      else if (s3_cancel_ff) s4_sum_in = '0;
      else s4_sum_in = {s3_sr_ff, e, m[22:0]};
   end

   always_ff @(posedge clock) begin
      if (advance) s4_sum_ff <= s4_sum_in;
   end

   assign rsp.valid = valid_ff[3];
   assign rsp.sum_bits = s4_sum_ff;
endmodule

FILE: dv/single_float_adder_truncating_checker.sv
`timescale 1ns / 1ps
module single_float_adder_truncating_checker
   import sfadd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sfadd_req_if.sink   req_mon,
   sfadd_rsp_if.sink   rsp_mon,
   output int          fail_count,
   output int          pending_count,
   output int          sum_count
);
   word_type sum_queue[$];

   // truncating add on bit patterns, no rounding, exponent wraps
   function automatic word_type predict_sum(word_type a, word_type b);
      logic     sign_a, sign_b, sign_r;
      exp_type  exp_a, exp_b, exp_r;
      logic [24:0] mant_a, mant_b, mant_r;
      int unsigned gap;
      sign_a = a[31];
      sign_b = b[31];
      exp_a = a[30:23];
      exp_b = b[30:23];
      if (a[30:0] == 31'd0) return b;
      if (b[30:0] == 31'd0) return a;
      mant_a = {2'b01, a[22:0]};
      mant_b = {2'b01, b[22:0]};
      if (exp_a < exp_b) begin
         gap = exp_b - exp_a;
         mant_a = (gap >= GapLimit) ? '0 : mant_a >> gap;
         exp_r = exp_b;
      end else begin
         gap = exp_a - exp_b;
         mant_b = (gap >= GapLimit) ? '0 : mant_b >> gap;
         exp_r = exp_a;
      end
      if (sign_a == sign_b) begin
         sign_r = sign_a;
         mant_r = mant_a + mant_b;
         if (mant_r[24]) begin
            mant_r = mant_r >> 1;
            exp_r = exp_r + 8'd1;
         end
      end else begin
         if (mant_a == mant_b) return '0;
         if (mant_b > mant_a) begin
            sign_r = sign_b;
            mant_r = mant_b - mant_a;
         end else begin
            sign_r = sign_a;
            mant_r = mant_a - mant_b;
         end
         // left normalize
         for (int i = 0; i < 24 && !mant_r[23]; i++) begin
            mant_r = mant_r << 1;
            exp_r = exp_r - 8'd1;
         end
      end
      return {sign_r, exp_r, mant_r[22:0]};
   endfunction

   initial begin
      fail_count = 0;
      sum_count = 0;
   end

   assign pending_count = sum_queue.size();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            sum_queue.push_back(predict_sum(req_mon.operand_a, req_mon.operand_b));
         if (rsp_mon.valid && rsp_mon.ready) begin
            sum_count++;
            if (sum_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word sum_bits=%h", $time, rsp_mon.sum_bits);
            end else begin
               if (sum_queue[0] !== rsp_mon.sum_bits) begin
                  fail_count++;
                  $display("%0t: sum_bits expected %h actual %h",
                           $time, sum_queue[0], rsp_mon.sum_bits);
               end
               void'(sum_queue.pop_front());
            end
         end
      end
   end
endmodule

FILE: dv/single_float_adder_truncating_test.sv
`timescale 1ns / 1ps
module single_float_adder_truncating_test;
   import sfadd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, sum_count;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   bit   hold_off = 1'b0;
   bit   hold_done = 1'b0;

   sfadd_req_if req_bus ();
   sfadd_rsp_if rsp_bus ();

   single_float_adder_truncating i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   single_float_adder_truncating_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus.sink),
      .rsp_mon       (rsp_bus.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .sum_count     (sum_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      rsp_bus.ready = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      wait (sum_count >= 300);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (60) @(posedge clock);
      hold_off = 1'b0;
      hold_done = 1'b1;
   end

   // build an operand with a chosen class
   function automatic word_type rand_operand(exp_type near_exp);
      word_type w;
      w = $urandom;
      case ($urandom_range(9))
         0: w[30:0] = '0;
         1: w[30:23] = near_exp + 8'($urandom_range(6)) - 8'd3;
         2: w[30:23] = near_exp + 8'($urandom_range(60)) - 8'd30;
         3: w[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_word(word_type a, word_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   word_type directed_a[$] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
      32'h3FC0_0000, 32'h4B80_0000, 32'h4C00_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF,
      32'h3F80_0001, 32'h0000_0001, 32'h7F80_0000, 32'h0080_0000, 32'hBF80_0000,
      32'h3F80_0000, 32'h4000_0000, 32'h5A5A_5A5A};
   word_type directed_b[$] = '{
      32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hBF80_0000,
      32'h3FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7F7F_FFFF, 32'h7FFF_FFFF,
      32'hBF80_0000, 32'h8000_0001, 32'hFF00_0000, 32'h8080_0001, 32'h3F7F_FFFF,
      32'hB3FF_FFFF, 32'h3300_0000, 32'hA5A5_A5A5};

   initial begin
      exp_type e;
      word_type a;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: zeros, cancel, wrap, gaps of 24/25/26, specials
      foreach (directed_a[i]) send_word(directed_a[i], directed_b[i]);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 19 : 0;
         for (int n = 0; n < 460; n++) begin
            a = rand_operand(8'($urandom));
            e = a[30:23];
            if ($urandom_range(4) == 0)
               send_word(a, {~a[31], a[30:0]} ^ 32'($urandom_range(1)));
            else
               send_word(a, rand_operand(e));
         end
      end
      req_bus.valid <= 1'b0;
      wait (pending_count == 0 && hold_done);
      repeat (10) @(posedge clock);
      $display("covered zero operands, cancellation, exponent wrap, wide gaps");
      $display("%0d sums checked under sender and receiver stalls", sum_count);
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end
endmodule

FILE: single_float_adder_truncating.f
rtl/core/sfadd_pkg.sv
rtl/core/sfadd_if.sv
rtl/core/single_float_adder_truncating.sv
dv/single_float_adder_truncating_checker.sv
dv/single_float_adder_truncating_test.sv
